// ----- design/adu_pkg.sv -----
`timescale 1ns / 1ps

package adu_pkg;

    // request codes
    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_SAME  = 2'd1,
        REQ_OPP   = 2'd2,
        REQ_QUERY = 2'd3
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_CONTRA = 2'd1,
        ST_RANGE  = 2'd2,
        ST_UNUSED = 2'd3
    } status_t;

    localparam int          RankW     = 4;
    localparam logic [3:0]  RankMax   = 4'd15;
    localparam int          CountW    = 11;
    localparam logic [10:0] CountInit = 11'd1024;

endpackage

// ----- design/agree_disagree_union_find.sv -----
`timescale 1ns / 1ps

// Union-find over MAX_NODES nodes with an enemy set per root, union by rank and
// set sizes, all held in one simple dual-port memory (one read and one write a cycle,
// read data registered) and worked by a small sequencer. After reset, and for a
// clear request, a clearing pass writes every entry, and a clear's result follows
// the pass; no item is taken during the pass after reset.
// A query reads every node below node_count once and a second entry for each
// opposed pair. A same-side or opposite-sides request walks parent links in up
// to six root searches (union by rank keeps a walk within log2 of the set size).
// An out-of-range request goes straight to its result. The block takes one item
// at a time; a result waits in the output register while the next item is
// accepted. The node count is written only while the block is idle.
module agree_disagree_union_find #(
    parameter int MAX_NODES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [9:0]  node_a,
    input  logic [9:0]  node_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [10:0] party_size,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int CNTW = (NW + 1 > adu_pkg::CountW) ? NW + 1 : adu_pkg::CountW;
    localparam logic [NW:0]     NoneRoot = (NW + 1)'(MAX_NODES);
    localparam logic [NW-1:0]   LastIdx  = NW'(MAX_NODES - 1);
    localparam logic [CNTW-1:0] MaxCount = CNTW'(MAX_NODES);

    typedef struct packed {
        logic [NW-1:0]              parent;
        logic [adu_pkg::RankW-1:0]  rank;
        logic [NW:0]                enemy;
        logic [NW:0]                size;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SWEEP, S_DISP, S_FIND, S_JN_CMP, S_JN_WR2, S_EN_WR,
        S_Q_CHK, S_Q_ADD, S_RESP
    } state_t;

    typedef enum logic [3:0] {
        P_FA, P_FB, P_DEC, P_J1A, P_J1B, P_J1C, P_J2A, P_J2B, P_J2C,
        P_E1, P_E2, P_FIN
    } step_t;

    // memory
    entry_t mem [MAX_NODES];
    entry_t rdata_reg;
    logic [NW-1:0] mem_addr;
    logic          mem_we;
    logic [NW-1:0] mem_waddr;
    entry_t        mem_wdata;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    adu_pkg::req_t req_reg, req_next;
    logic [NW-1:0] a_reg, a_next, b_reg, b_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic          slot_reg, slot_next;
    logic [NW-1:0] root0_reg, root0_next, root1_reg, root1_next;
    entry_t        ent0_reg, ent0_next, ent1_reg, ent1_next;
    logic [NW:0]   ra_reg, ra_next, rb_reg, rb_next, ea_reg, ea_next, eb_reg, eb_next;
    logic [NW:0]   x_reg, x_next, y_reg, y_next;
    logic [NW-1:0] hi_addr_reg, hi_addr_next;
    entry_t        hi_ent_reg, hi_ent_next;
    logic [NW-1:0] en_addr_reg, en_addr_next;
    logic [NW:0]   en_val_reg, en_val_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW:0]   s_hold_reg, s_hold_next;
    logic [NW:0]   party_reg, party_next;
    logic [NW-1:0] sw_reg, sw_next;
    logic          clr_resp_reg, clr_resp_next;
    adu_pkg::status_t res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [10:0]   party_size_reg, party_size_next;
    logic [10:0]   node_count_reg, node_count_next;

    // working values
    logic [CNTW-1:0] count_eff;
    logic [NW:0]     op_u, op_v;
    logic            is_j1;
    logic [NW:0]     jres;
    logic            swap;
    logic [NW-1:0]   lo_root, hi_root;
    entry_t          lo_ent, hi_ent;
    logic            q_adv;
    logic [NW:0]     q_add;

    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign party_size = party_size_reg;

    assign count_eff = (CNTW'(node_count_reg) > MaxCount) ? MaxCount
                                                           : CNTW'(node_count_reg);

    // join operands for the current step
    always_comb
    begin
        is_j1 = (step_reg == P_J1A) || (step_reg == P_J1B) || (step_reg == P_J1C);
        if (req_reg == adu_pkg::REQ_SAME)
        begin
            op_u = is_j1 ? ra_reg : ea_reg;
            op_v = is_j1 ? rb_reg : eb_reg;
        end
        else
        begin
            op_u = is_j1 ? ra_reg : rb_reg;
            op_v = is_j1 ? eb_reg : ea_reg;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        req_next        = req_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        cur_next        = cur_reg;
        slot_next       = slot_reg;
        root0_next      = root0_reg;
        root1_next      = root1_reg;
        ent0_next       = ent0_reg;
        ent1_next       = ent1_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        ea_next         = ea_reg;
        eb_next         = eb_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        hi_addr_next    = hi_addr_reg;
        hi_ent_next     = hi_ent_reg;
        en_addr_next    = en_addr_reg;
        en_val_next     = en_val_reg;
        i_next          = i_reg;
        s_hold_next     = s_hold_reg;
        party_next      = party_reg;
        sw_next         = sw_reg;
        clr_resp_next   = clr_resp_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        party_size_next = party_size_reg;
        node_count_next = (cfg_valid && cfg_ready) ? cfg_data : node_count_reg;

        mem_addr  = cur_reg;
        mem_we    = 1'b0;
        mem_waddr = sw_reg;
        mem_wdata = rdata_reg;

        jres    = '0;
        swap    = 1'b0;
        lo_root = root0_reg;
        hi_root = root1_reg;
        lo_ent  = ent0_reg;
        hi_ent  = ent1_reg;
        q_adv   = 1'b0;
        q_add   = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = adu_pkg::req_t'(req_type);
                    a_next     = NW'(node_a);
                    b_next     = NW'(node_b);
                    party_next = '0;
                    res_next   = adu_pkg::ST_OK;
                    case (adu_pkg::req_t'(req_type))
                        adu_pkg::REQ_CLEAR:
                        begin
                            sw_next       = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_SWEEP;
                        end
                        adu_pkg::REQ_QUERY:
                        begin
                            i_next   = '0;
                            mem_addr = '0;
                            state_next = (count_eff == '0) ? S_RESP : S_Q_CHK;
                        end
                        default:
                        begin
                            if ((CNTW'(node_a) >= count_eff) ||
                                (CNTW'(node_b) >= count_eff))
                            begin
                                res_next   = adu_pkg::ST_RANGE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                step_next  = P_FA;
                                state_next = S_DISP;
                            end
                        end
                    endcase
                end
            end

            // clearing pass, one entry a cycle
            S_SWEEP:
            begin
                mem_we           = 1'b1;
                mem_waddr        = sw_reg;
                mem_wdata.parent = sw_reg;
                mem_wdata.rank   = '0;
                mem_wdata.enemy  = NoneRoot;
                mem_wdata.size   = (NW + 1)'(1);
                if (sw_reg == LastIdx)
                begin
                    state_next = clr_resp_reg ? S_RESP : S_IDLE;
                end
                else
                begin
                    sw_next = sw_reg + NW'(1);
                end
            end

            // micro-program dispatch
            S_DISP:
            begin
                case (step_reg)
                    P_FA:
                    begin
                        mem_addr   = a_reg;
                        cur_next   = a_reg;
                        slot_next  = 1'b0;
                        step_next  = P_FB;
                        state_next = S_FIND;
                    end
                    P_FB:
                    begin
                        mem_addr   = b_reg;
                        cur_next   = b_reg;
                        slot_next  = 1'b1;
                        step_next  = P_DEC;
                        state_next = S_FIND;
                    end
                    P_DEC:
                    begin
                        ra_next = {1'b0, root0_reg};
                        rb_next = {1'b0, root1_reg};
                        ea_next = ent0_reg.enemy;
                        eb_next = ent1_reg.enemy;
                        if (((req_reg == adu_pkg::REQ_SAME) &&
                             (ent0_reg.enemy == {1'b0, root1_reg})) ||
                            ((req_reg != adu_pkg::REQ_SAME) && (root0_reg == root1_reg)))
                        begin
                            res_next   = adu_pkg::ST_CONTRA;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            step_next = P_J1A;
                        end
                    end
                    P_J1A, P_J2A:
                    begin
                        if ((op_u == NoneRoot) || (op_v == NoneRoot))
                        begin
                            jres = (op_u == NoneRoot) ? op_v : op_u;
                            if (is_j1)
                            begin
                                x_next    = jres;
                                step_next = P_J2A;
                            end
                            else
                            begin
                                y_next    = jres;
                                step_next = P_E1;
                            end
                        end
                        else
                        begin
                            mem_addr   = op_u[NW-1:0];
                            cur_next   = op_u[NW-1:0];
                            slot_next  = 1'b0;
                            step_next  = is_j1 ? P_J1B : P_J2B;
                            state_next = S_FIND;
                        end
                    end
                    P_J1B, P_J2B:
                    begin
                        mem_addr   = op_v[NW-1:0];
                        cur_next   = op_v[NW-1:0];
                        slot_next  = 1'b1;
                        step_next  = is_j1 ? P_J1C : P_J2C;
                        state_next = S_FIND;
                    end
                    P_J1C, P_J2C:
                    begin
                        state_next = S_JN_CMP;
                    end
                    P_E1:
                    begin
                        en_addr_next = x_reg[NW-1:0];
                        en_val_next  = y_reg;
                        mem_addr     = x_reg[NW-1:0];
                        step_next    = P_E2;
                        state_next   = S_EN_WR;
                    end
                    P_E2:
                    begin
                        if (y_reg == NoneRoot)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            en_addr_next = y_reg[NW-1:0];
                            en_val_next  = x_reg;
                            mem_addr     = y_reg[NW-1:0];
                            step_next    = P_FIN;
                            state_next   = S_EN_WR;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            // walk parent links, one per cycle
            S_FIND:
            begin
                if (rdata_reg.parent == cur_reg)
                begin
                    if (slot_reg)
                    begin
                        root1_next = cur_reg;
                        ent1_next  = rdata_reg;
                    end
                    else
                    begin
                        root0_next = cur_reg;
                        ent0_next  = rdata_reg;
                    end
                    state_next = S_DISP;
                end
                else
                begin
                    cur_next = rdata_reg.parent;
                    mem_addr = rdata_reg.parent;
                end
            end

            // union by rank: hang the lower tree under the higher
            S_JN_CMP:
            begin
                if (root0_reg == root1_reg)
                begin
                    jres       = {1'b0, root0_reg};
                    state_next = S_DISP;
                end
                else
                begin
                    swap = ent0_reg.rank > ent1_reg.rank;
                    lo_root = swap ? root1_reg : root0_reg;
                    hi_root = swap ? root0_reg : root1_reg;
                    lo_ent  = swap ? ent1_reg : ent0_reg;
                    hi_ent  = swap ? ent0_reg : ent1_reg;
                    mem_we           = 1'b1;
                    mem_waddr        = lo_root;
                    mem_wdata        = lo_ent;
                    mem_wdata.parent = hi_root;
                    hi_ent_next      = hi_ent;
                    if ((lo_ent.rank == hi_ent.rank) && (hi_ent.rank < adu_pkg::RankMax))
                    begin
                        hi_ent_next.rank = hi_ent.rank + adu_pkg::RankW'(1);
                    end
                    hi_ent_next.size = hi_ent.size + lo_ent.size;
                    hi_addr_next     = hi_root;
                    jres             = {1'b0, hi_root};
                    state_next       = S_JN_WR2;
                end
                if (step_reg == P_J1C)
                begin
                    x_next    = jres;
                    step_next = P_J2A;
                end
                else
                begin
                    y_next    = jres;
                    step_next = P_E1;
                end
            end

            S_JN_WR2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = hi_addr_reg;
                mem_wdata  = hi_ent_reg;
                state_next = S_DISP;
            end

            // read-modify-write of an enemy link
            S_EN_WR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = en_addr_reg;
                mem_wdata       = rdata_reg;
                mem_wdata.enemy = en_val_reg;
                state_next      = S_DISP;
            end

            // query scan over roots
            S_Q_CHK:
            begin
                if (rdata_reg.parent == i_reg)
                begin
                    if (rdata_reg.enemy == NoneRoot)
                    begin
                        party_next = party_reg + rdata_reg.size;
                        q_adv      = 1'b1;
                    end
                    else if (rdata_reg.enemy > {1'b0, i_reg})
                    begin
                        q_adv = 1'b1;
                    end
                    else
                    begin
                        s_hold_next = rdata_reg.size;
                        mem_addr    = rdata_reg.enemy[NW-1:0];
                        state_next  = S_Q_ADD;
                    end
                end
                else
                begin
                    q_adv = 1'b1;
                end
            end

            S_Q_ADD:
            begin
                q_add      = (s_hold_reg > rdata_reg.size) ? s_hold_reg : rdata_reg.size;
                party_next = party_reg + q_add;
                q_adv      = 1'b1;
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_reg;
                    party_size_next = 11'(party_reg);
                    clr_resp_next   = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // next node of the query scan
        if (q_adv)
        begin
            if ((CNTW'(i_reg) + CNTW'(1)) == count_eff)
            begin
                state_next = S_RESP;
            end
            else
            begin
                i_next     = i_reg + NW'(1);
                mem_addr   = i_reg + NW'(1);
                state_next = S_Q_CHK;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            step_reg       <= P_FA;
            req_reg        <= adu_pkg::REQ_CLEAR;
            a_reg          <= '0;
            b_reg          <= '0;
            cur_reg        <= '0;
            slot_reg       <= 1'b0;
            root0_reg      <= '0;
            root1_reg      <= '0;
            ent0_reg       <= '0;
            ent1_reg       <= '0;
            ra_reg         <= '0;
            rb_reg         <= '0;
            ea_reg         <= '0;
            eb_reg         <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            hi_addr_reg    <= '0;
            hi_ent_reg     <= '0;
            en_addr_reg    <= '0;
            en_val_reg     <= '0;
            i_reg          <= '0;
            s_hold_reg     <= '0;
            party_reg      <= '0;
            sw_reg         <= '0;
            clr_resp_reg   <= 1'b0;
            res_reg        <= adu_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            status_reg     <= '0;
            party_size_reg <= '0;
            node_count_reg <= adu_pkg::CountInit;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            req_reg        <= req_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            cur_reg        <= cur_next;
            slot_reg       <= slot_next;
            root0_reg      <= root0_next;
            root1_reg      <= root1_next;
            ent0_reg       <= ent0_next;
            ent1_reg       <= ent1_next;
            ra_reg         <= ra_next;
            rb_reg         <= rb_next;
            ea_reg         <= ea_next;
            eb_reg         <= eb_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            hi_addr_reg    <= hi_addr_next;
            hi_ent_reg     <= hi_ent_next;
            en_addr_reg    <= en_addr_next;
            en_val_reg     <= en_val_next;
            i_reg          <= i_next;
            s_hold_reg     <= s_hold_next;
            party_reg      <= party_next;
            sw_reg         <= sw_next;
            clr_resp_reg   <= clr_resp_next;
            res_reg        <= res_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            party_size_reg <= party_size_next;
            node_count_reg <= node_count_next;
        end
    end

    // node table, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int NODES = 1024;
    localparam logic [10:0] NONE = 11'd1024;
    localparam int WATCH_LIMIT = 40000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [9:0]  node_a;
    logic [9:0]  node_b;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [10:0] party_size;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    agree_disagree_union_find u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .node_a     (node_a),
        .node_b     (node_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .party_size (party_size),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state
    logic [9:0]  link_m [NODES];
    logic [3:0]  rank_m [NODES];
    logic [10:0] foe_m  [NODES];
    logic [10:0] size_m [NODES];
    logic [10:0] count_m;

    typedef struct packed {
        logic [1:0]  st;
        logic [10:0] party;
    } answer_t;

    answer_t answers_due[$];
    int      errors;
    int      idle_cycles;
    int      sent_items;
    int      got_items;
    int      contra_seen;
    int      range_seen;

    function automatic void wipe_sets();
        for (int i = 0; i < NODES; i++)
        begin
            link_m[i] = 10'(i);
            rank_m[i] = 4'd0;
            foe_m[i]  = NONE;
            size_m[i] = 11'd1;
        end
    endfunction

    function automatic logic [9:0] find_root(logic [9:0] u);
        logic [9:0] w;
        w = u;
        while (link_m[w] != w)
            w = link_m[w];
        return w;
    endfunction

    // merge two sets, either may be none
    function automatic logic [10:0] merge_sets(logic [10:0] u, logic [10:0] v);
        logic [9:0] ru;
        logic [9:0] rv;
        logic [9:0] t;
        if (u >= NONE || v >= NONE)
            return (u >= NONE) ? v : u;
        ru = find_root(u[9:0]);
        rv = find_root(v[9:0]);
        if (ru == rv)
            return {1'b0, ru};
        if (rank_m[ru] > rank_m[rv])
        begin
            t = ru;
            ru = rv;
            rv = t;
        end
        if (rank_m[ru] == rank_m[rv] && rank_m[rv] < adu_pkg::RankMax)
            rank_m[rv] = rank_m[rv] + 4'd1;
        link_m[ru] = rv;
        size_m[rv] = size_m[rv] + size_m[ru];
        return {1'b0, rv};
    endfunction

    function automatic answer_t resolve_request(adu_pkg::req_t rq, logic [9:0] a,
                                                logic [9:0] b);
        answer_t    r;
        int         n;
        logic [9:0] ra;
        logic [9:0] rb;
        logic [10:0] ea;
        logic [10:0] eb;
        logic [10:0] x;
        logic [10:0] y;
        logic [10:0] s;
        logic [10:0] es;
        r.st = adu_pkg::ST_OK;
        r.party = 11'd0;
        n = (count_m > NONE) ? NODES : int'(count_m);
        if (rq == adu_pkg::REQ_CLEAR)
            wipe_sets();
        else if (rq == adu_pkg::REQ_QUERY)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (link_m[i] == 10'(i))
                begin
                    s = size_m[i];
                    es = 11'd0;
                    if (foe_m[i] < NONE)
                    begin
                        if (foe_m[i] > 11'(i))
                            continue;
                        es = size_m[foe_m[i][9:0]];
                    end
                    r.party = r.party + ((s > es) ? s : es);
                end
            end
        end
        else if (int'(a) >= n || int'(b) >= n)
            r.st = adu_pkg::ST_RANGE;
        else
        begin
            ra = find_root(a);
            rb = find_root(b);
            if (rq == adu_pkg::REQ_SAME)
            begin
                if (foe_m[ra] == {1'b0, rb})
                    r.st = adu_pkg::ST_CONTRA;
                else
                begin
                    ea = foe_m[ra];
                    eb = foe_m[rb];
                    x = merge_sets({1'b0, ra}, {1'b0, rb});
                    y = merge_sets(ea, eb);
                    foe_m[x[9:0]] = y;
                    if (y < NONE)
                        foe_m[y[9:0]] = x;
                end
            end
            else if (ra == rb)
                r.st = adu_pkg::ST_CONTRA;
            else
            begin
                x = merge_sets({1'b0, ra}, foe_m[rb]);
                y = merge_sets({1'b0, rb}, foe_m[ra]);
                foe_m[x[9:0]] = y;
                foe_m[y[9:0]] = x;
            end
        end
        return r;
    endfunction

    // directed table: typed expectation used only where flagged
    typedef struct {
        adu_pkg::req_t rq;
        logic [9:0]    a;
        logic [9:0]    b;
        logic          typed;
        logic [1:0]    st;
        logic [10:0]   party;
    } row_t;

    row_t table_rows [12] = '{
        '{adu_pkg::REQ_QUERY, 10'd0,    10'd0,    1'b1, adu_pkg::ST_OK,     11'd1024},
        '{adu_pkg::REQ_SAME,  10'd0,    10'd1023, 1'b1, adu_pkg::ST_OK,     11'd0},
        '{adu_pkg::REQ_OPP,   10'd0,    10'd1023, 1'b1, adu_pkg::ST_CONTRA, 11'd0},
        '{adu_pkg::REQ_OPP,   10'd1,    10'd2,    1'b0, adu_pkg::ST_OK,     11'd0},
        '{adu_pkg::REQ_SAME,  10'd1,    10'd2,    1'b1, adu_pkg::ST_CONTRA, 11'd0},
        '{adu_pkg::REQ_SAME,  10'd3,    10'd3,    1'b0, adu_pkg::ST_OK,     11'd0},
        '{adu_pkg::REQ_OPP,   10'd4,    10'd4,    1'b1, adu_pkg::ST_CONTRA, 11'd0},
        '{adu_pkg::REQ_OPP,   10'd2,    10'd5,    1'b0, adu_pkg::ST_OK,     11'd0},
        '{adu_pkg::REQ_SAME,  10'd1,    10'd5,    1'b0, adu_pkg::ST_OK,     11'd0},
        '{adu_pkg::REQ_QUERY, 10'd1023, 10'd1023, 1'b0, adu_pkg::ST_OK,     11'd0},
        '{adu_pkg::REQ_CLEAR, 10'd1023, 10'd1023, 1'b1, adu_pkg::ST_OK,     11'd0},
        '{adu_pkg::REQ_QUERY, 10'd5,    10'd6,    1'b1, adu_pkg::ST_OK,     11'd1024}
    };

    // short tables for shrunk counts
    row_t small_rows [3] = '{
        '{adu_pkg::REQ_SAME,  10'd0,    10'd0,    1'b1, adu_pkg::ST_RANGE,  11'd0},
        '{adu_pkg::REQ_OPP,   10'd1023, 10'd0,    1'b1, adu_pkg::ST_RANGE,  11'd0},
        '{adu_pkg::REQ_QUERY, 10'd0,    10'd0,    1'b0, adu_pkg::ST_OK,     11'd0}
    };

    // append an expected answer at the tail of the queue
    task automatic queue_answer(answer_t p);
        answers_due.insert(answers_due.size(), p);
    endtask

    // sender: one item with random gap, waits for acceptance
    task automatic send_item(adu_pkg::req_t rq, logic [9:0] a, logic [9:0] b);
        int gap;
        gap = $urandom_range(0, 18);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        node_a   <= a;
        node_b   <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic run_row(row_t r);
        answer_t p;
        p = resolve_request(r.rq, r.a, r.b);
        if (r.typed && (p.st != r.st || p.party != r.party))
            $display("%0t table row disagrees with predictor: exp %0d/%0d pred %0d/%0d",
                     $time, r.st, r.party, p.st, p.party);
        if (r.typed)
        begin
            p.st = r.st;
            p.party = r.party;
        end
        queue_answer(p);
        send_item(r.rq, r.a, r.b);
    endtask

    task automatic drain_answers();
        in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(negedge clk);
        repeat (2200) @(negedge clk);
    endtask

    task automatic set_count(logic [10:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        count_m = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random relation mostly among a few low ids so sets grow deep
    task automatic random_phase(int items, int span);
        int    k;
        adu_pkg::req_t rq;
        logic [9:0] a;
        logic [9:0] b;
        for (int i = 0; i < items; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 2)
                rq = adu_pkg::REQ_CLEAR;
            else if (k < 8)
                rq = adu_pkg::REQ_QUERY;
            else if (k < 54)
                rq = adu_pkg::REQ_SAME;
            else
                rq = adu_pkg::REQ_OPP;
            if ($urandom_range(0, 9) == 0)
            begin
                a = 10'($urandom);
                b = 10'($urandom);
            end
            else
            begin
                a = 10'($urandom_range(0, span - 1));
                b = 10'($urandom_range(0, span - 1));
            end
            queue_answer(resolve_request(rq, a, b));
            send_item(rq, a, b);
            if (i == items / 2)
            begin
                // hold off until all answers are in
                in_valid <= 1'b0;
                while (answers_due.size() != 0)
                    @(negedge clk);
            end
        end
    endtask

    // receiver with random stall
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            gap = $urandom_range(0, 18);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // result check
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && out_ready)
        begin
            got_items++;
            if (answers_due.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %0d/%0d",
                         $time, status, party_size);
                errors++;
            end
            else
            begin
                e = answers_due.pop_front();
                if (status == adu_pkg::ST_CONTRA) contra_seen++;
                if (status == adu_pkg::ST_RANGE) range_seen++;
                if (status !== e.st)
                begin
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, e.st, status);
                    errors++;
                end
                if (party_size !== e.party)
                begin
                    $display("%0t party_size mismatch: expected %0d, actual %0d",
                             $time, e.party, party_size);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no acceptance
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        sent_items = 0;
        got_items = 0;
        contra_seen = 0;
        range_seen = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = adu_pkg::REQ_CLEAR;
        node_a = '0;
        node_b = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        count_m = adu_pkg::CountInit;
        wipe_sets();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (table_rows[i])
            run_row(table_rows[i]);
        random_phase(700, 24);
        drain_answers();

        // zero count
        set_count(11'd0);
        foreach (small_rows[i])
            run_row(small_rows[i]);
        drain_answers();

        // shrunk count with state left above it
        set_count(11'd17);
        random_phase(500, 24);
        drain_answers();

        // count beyond the node range clamps, top bit set
        set_count(11'd2047);
        random_phase(300, 64);
        drain_answers();

        set_count(11'd1);
        random_phase(100, 4);
        drain_answers();

        set_count(11'd1024);
        random_phase(300, 1024);
        drain_answers();

        $display("ran %0d items, %0d results, %0d contradictions, %0d out of range",
                 sent_items, got_items, contra_seen, range_seen);
        $display("node counts 1024, 0, 17, 2047, 1 and 1024 again, clears and queries mixed in");
        if (errors == 0 && answers_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/adu_pkg.sv
design/agree_disagree_union_find.sv
bench/testbench.sv
